// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignoring cycles in reset.
`define WFN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define WFN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/wfn_pkg.sv
// ----------------------------------------------------------------------------
// wfn_pkg
// Types, codes and helpers shared by the wall-follow navigation sequencer.
// ----------------------------------------------------------------------------
package wfn_pkg;

    // Event kinds carried on the input tuser
    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_SENSOR    = 3'd1,
        KIND_ROT_DONE  = 3'd2,
        KIND_DIST_DONE = 3'd3,
        KIND_STOP      = 3'd4,
        KIND_CONTINUE  = 3'd5,
        KIND_PAUSE     = 3'd6,
        KIND_RESTART   = 3'd7
    } kind_t;

    // Motion command codes
    typedef enum logic [2:0] {
        CMD_ROTATE  = 3'd0,
        CMD_DIST    = 3'd1,
        CMD_FORWARD = 3'd2,
        CMD_PAUSE   = 3'd3,
        CMD_CONT    = 3'd4
    } cmd_t;

    // Navigation states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_GET_OFFSET = 7'b0000010,
        ST_ROT_FRONT  = 7'b0000100,
        ST_COR_OFFSET = 7'b0001000,
        ST_ROT_BACK   = 7'b0010000,
        ST_GET_ANGLE  = 7'b0100000,
        ST_DRIVE      = 7'b1000000
    } nav_st_t;

    // External state codes reported on seq_state
    localparam logic [2:0] NAV_CODE_IDLE       = 3'd0;
    localparam logic [2:0] NAV_CODE_GET_OFFSET = 3'd1;
    localparam logic [2:0] NAV_CODE_ROT_FRONT  = 3'd2;
    localparam logic [2:0] NAV_CODE_COR_OFFSET = 3'd3;
    localparam logic [2:0] NAV_CODE_ROT_BACK   = 3'd4;
    localparam logic [2:0] NAV_CODE_GET_ANGLE  = 3'd5;
    localparam logic [2:0] NAV_CODE_DRIVE      = 3'd6;
    localparam logic [2:0] NAV_CODE_SPARE      = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_OFFSET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT      = 2'd2;

    // Configuration reset values
    localparam logic [9:0] TARGET_OFFSET_RST    = 10'd30;
    localparam logic [7:0] OFFSET_TOLERANCE_RST = 8'd5;
    localparam logic [6:0] ANGLE_LIMIT_RST      = 7'd5;

    // Fixed turn angles and forward drive argument
    localparam logic signed [15:0] ROT_QUARTER     = 16'sd90;
    localparam logic signed [15:0] ROT_QUARTER_NEG = -16'sd90;
    localparam logic signed [15:0] FORWARD_ARG     = 16'sd1;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 24;

    // One accepted input word
    typedef struct packed {
        kind_t              kind;
        logic [15:0]        wall_offset;
        logic signed [7:0]  wall_angle;
        logic [15:0]        front_distance;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic               cmd_valid;
        cmd_t               cmd_code;
        logic signed [15:0] cmd_value;
        logic [2:0]         seq_state;
        logic               corner_flag;
    } result_t;

    // Configuration write bundle
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Map a one-hot state to its reported code
    function automatic logic [2:0] nav_code(input nav_st_t s);
        logic [2:0] code;
        unique case (s)
            ST_IDLE:       code = NAV_CODE_IDLE;
            ST_GET_OFFSET: code = NAV_CODE_GET_OFFSET;
            ST_ROT_FRONT:  code = NAV_CODE_ROT_FRONT;
            ST_COR_OFFSET: code = NAV_CODE_COR_OFFSET;
            ST_ROT_BACK:   code = NAV_CODE_ROT_BACK;
            ST_GET_ANGLE:  code = NAV_CODE_GET_ANGLE;
            ST_DRIVE:      code = NAV_CODE_DRIVE;
            default:       code = NAV_CODE_SPARE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/wall_follow_nav_sequencer_core.sv
// ----------------------------------------------------------------------------
// wall_follow_nav_sequencer_core
// Wall-following navigation sequencer: one result word per event word.
// ----------------------------------------------------------------------------
// Usage:
//   Event words enter on the s_axis channel; tuser carries the event kind
//   and tdata the sensor fields (used by sensor events only). Every event
//   produces exactly one result word on the m_axis channel; tuser flags a
//   motion command, tdata carries the command, argument, state and corner
//   flag. Thresholds are to be written through cfg_we / cfg_index / cfg_data
//   only while no event is in flight; the block itself does not enforce this.
//   Path: an accepted event word passes through the input register, then
//   the decision logic into the result register.
//   Throughput: one event per cycle while results are taken; the decision
//   logic reads and updates the navigation state in a single pass.
//   Reset: both stages empty, state idle, not running, latched sensor data
//   and flags cleared, thresholds back to 30 / 5 / 5.
//   Stall: a held result waits in the result register; the input register
//   still takes one more word, then s_axis_tready drops until the receiver
//   takes the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wall_follow_nav_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [wfn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wfn_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Event input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] wall_offset, [23:16] wall_angle, [39:24] front_distance
    input  logic [wfn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]                          s_axis_tuser,
    // Result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] cmd_code, [18:3] cmd_value, [21:19] seq_state, [22] corner_flag,
    // [23] zero
    output logic [wfn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] cmd_valid
    output logic [0:0]                          m_axis_tuser
);

    wfn_pkg::in_word_t in_word;
    wfn_pkg::in_word_t held_word;
    wfn_pkg::cfg_wr_t  cfg;
    wfn_pkg::result_t  res_core;
    wfn_pkg::result_t  res_out;
    logic              in_valid;
    logic              out_free;
    logic              advance;
    logic              out_stall;
    logic              cmd_fields_zero;
    logic              spare_shown;

    // Unpack the input word
    assign in_word.kind           = wfn_pkg::kind_t'(s_axis_tuser);
    assign in_word.wall_offset    = s_axis_tdata[15:0];
    assign in_word.wall_angle     = $signed(s_axis_tdata[23:16]);
    assign in_word.front_distance = s_axis_tdata[39:24];

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Move a held event into the result register when there is room
    assign advance = in_valid && out_free;

    wfn_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (in_word),
        .take     (advance),
        .valid    (in_valid),
        .word     (held_word)
    );

    wfn_nav_core u_nav_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .word    (held_word),
        .res     (res_core)
    );

    wfn_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_core),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_out   (res_out)
    );

    // Pack the result word
    assign m_axis_tdata = {1'b0, res_out.corner_flag, res_out.seq_state,
                           res_out.cmd_value, res_out.cmd_code};
    assign m_axis_tuser = res_out.cmd_valid;

    // Terms used by the checks below
    assign out_stall       = m_axis_tvalid && !m_axis_tready;
    assign cmd_fields_zero = (m_axis_tdata[18:0] == 19'd0);
    assign spare_shown     = (res_out.seq_state == wfn_pkg::NAV_CODE_SPARE);

    // No result may show while in reset
    `WFN_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_n |-> !m_axis_tvalid, "result valid in reset")

    // A word moved out of the input register is shown on the next cycle
    `WFN_ASSERT(a_advance_shows, advance |=> m_axis_tvalid, "advanced word not shown")

    // Both stages full and stalled: no further word may be taken
    `WFN_ASSERT(a_full_blocks, (in_valid && out_stall) |-> !s_axis_tready, "accept while full")

    // Without a command the code and argument fields are zero
    `WFN_ASSERT(a_idle_cmd_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> cmd_fields_zero, "stale cmd")

    // The spare state code is never reported
    `WFN_ASSERT(a_no_spare, m_axis_tvalid |-> !spare_shown, "spare state reported")

endmodule

// File: hw/rtl/wfn_in_stage.sv
// ----------------------------------------------------------------------------
// wfn_in_stage
// Input register: holds one accepted event word until the core takes it.
// ----------------------------------------------------------------------------
module wfn_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wfn_pkg::in_word_t in_word,
    input  logic              take,
    output logic              valid,
    output wfn_pkg::in_word_t word
);

    logic              valid_reg;
    wfn_pkg::in_word_t word_reg;

    // Free when empty or when the held word leaves this cycle
    assign in_ready = !valid_reg || take;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

// File: hw/rtl/wfn_nav_core.sv
// ----------------------------------------------------------------------------
// wfn_nav_core
// Navigation state, latched sensor data, config registers and the
// single-pass event decision logic.
// ----------------------------------------------------------------------------
module wfn_nav_core (
    input  logic              clk,
    input  logic              rst_n,
    input  wfn_pkg::cfg_wr_t  cfg,
    input  logic              advance,
    input  wfn_pkg::in_word_t word,
    output wfn_pkg::result_t  res
);

    // Configuration
    logic [9:0] target_offset_reg;
    logic [7:0] offset_tolerance_reg;
    logic [6:0] angle_limit_reg;

    // Navigation state
    wfn_pkg::nav_st_t cur_reg, cur_next;
    wfn_pkg::nav_st_t pend_reg, pend_next;
    logic             corner_reg, corner_next;
    logic             rot_reg, rot_next;
    logic             dist_reg, dist_next;
    logic             fresh_reg, fresh_next;
    logic             run_reg, run_next;
    logic [15:0]      lat_off_reg, lat_off_next;
    logic [7:0]       lat_ang_reg, lat_ang_next;
    logic [15:0]      lat_front_reg, lat_front_next;

    // Command under construction
    logic               emit_valid;
    wfn_pkg::cmd_t      emit_code;
    logic signed [15:0] emit_value;

    // Derived quantities from latched data
    logic signed [15:0] ang_ext;
    logic signed [15:0] ang_neg;
    logic signed [15:0] rot_front_arg;
    logic signed [15:0] dist_arg;
    logic [7:0]         ang_mag;
    logic               ang_over;
    logic signed [17:0] off_ext;
    logic signed [17:0] win_hi;
    logic signed [17:0] win_lo;
    logic               in_window;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_offset_reg    <= wfn_pkg::TARGET_OFFSET_RST;
            offset_tolerance_reg <= wfn_pkg::OFFSET_TOLERANCE_RST;
            angle_limit_reg      <= wfn_pkg::ANGLE_LIMIT_RST;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                wfn_pkg::REG_TARGET_OFFSET:    target_offset_reg    <= cfg.data;
                wfn_pkg::REG_OFFSET_TOLERANCE: offset_tolerance_reg <= cfg.data[7:0];
                wfn_pkg::REG_ANGLE_LIMIT:      angle_limit_reg      <= cfg.data[6:0];
                default: ;
            endcase
        end
    end

    // Angle forms used by the rotate commands and the drift check
    assign ang_ext       = $signed({{8{lat_ang_reg[7]}}, lat_ang_reg});
    assign ang_neg       = -ang_ext;
    assign rot_front_arg = wfn_pkg::ROT_QUARTER - ang_ext;
    assign dist_arg      = $signed(lat_front_reg - {6'b0, target_offset_reg});
    assign ang_mag       = lat_ang_reg[7] ? (~lat_ang_reg + 8'd1) : lat_ang_reg;
    assign ang_over      = ang_mag > {1'b0, angle_limit_reg};

    // Offset window, both ends exclusive
    assign off_ext   = $signed({2'b00, lat_off_reg});
    assign win_hi    = $signed({8'b0, target_offset_reg} + {10'b0, offset_tolerance_reg});
    assign win_lo    = $signed({8'b0, target_offset_reg} - {10'b0, offset_tolerance_reg});
    assign in_window = (off_ext < win_hi) && (off_ext > win_lo);

    // Decide next state and command for the current event
    always_comb
    begin
        cur_next       = cur_reg;
        pend_next      = pend_reg;
        corner_next    = corner_reg;
        rot_next       = rot_reg;
        dist_next      = dist_reg;
        fresh_next     = fresh_reg;
        run_next       = run_reg;
        lat_off_next   = lat_off_reg;
        lat_ang_next   = lat_ang_reg;
        lat_front_next = lat_front_reg;
        emit_valid     = 1'b0;
        emit_code      = wfn_pkg::CMD_ROTATE;
        emit_value     = '0;

        unique case (word.kind)
            wfn_pkg::KIND_TICK:
            begin
                // Next-state selection only while running
                if (run_reg)
                begin
                    unique case (cur_reg)
                        wfn_pkg::ST_IDLE:
                        begin
                            pend_next   = wfn_pkg::ST_GET_OFFSET;
                            corner_next = 1'b0;
                        end
                        wfn_pkg::ST_GET_OFFSET:
                        begin
                            corner_next = 1'b0;
                            pend_next   = in_window ? wfn_pkg::ST_GET_ANGLE
                                                    : wfn_pkg::ST_ROT_FRONT;
                        end
                        wfn_pkg::ST_ROT_FRONT:
                        begin
                            corner_next = 1'b1;
                            if (rot_reg)
                            begin
                                pend_next = wfn_pkg::ST_COR_OFFSET;
                                rot_next  = 1'b0;
                            end
                        end
                        wfn_pkg::ST_COR_OFFSET:
                        begin
                            corner_next = 1'b1;
                            if (dist_reg)
                            begin
                                pend_next = wfn_pkg::ST_ROT_BACK;
                                dist_next = 1'b0;
                            end
                        end
                        wfn_pkg::ST_ROT_BACK:
                        begin
                            corner_next = 1'b1;
                            if (rot_reg)
                            begin
                                pend_next = wfn_pkg::ST_DRIVE;
                                rot_next  = 1'b0;
                            end
                        end
                        wfn_pkg::ST_GET_ANGLE:
                        begin
                            if (rot_reg)
                            begin
                                corner_next = 1'b0;
                                pend_next   = wfn_pkg::ST_DRIVE;
                                rot_next    = 1'b0;
                            end
                        end
                        wfn_pkg::ST_DRIVE:
                        begin
                            corner_next = 1'b0;
                            if (ang_over)
                            begin
                                pend_next = wfn_pkg::ST_GET_ANGLE;
                            end
                        end
                        default:
                        begin
                            corner_next = 1'b0;
                            pend_next   = wfn_pkg::ST_IDLE;
                        end
                    endcase
                end

                // Transition action: compare current and pending state
                unique case (cur_reg)
                    wfn_pkg::ST_GET_OFFSET:
                    begin
                        if (pend_next == wfn_pkg::ST_GET_ANGLE)
                        begin
                            emit_valid = 1'b1;
                            emit_code  = wfn_pkg::CMD_ROTATE;
                            emit_value = ang_neg;
                        end
                        else if (pend_next == wfn_pkg::ST_ROT_FRONT)
                        begin
                            emit_valid = 1'b1;
                            emit_code  = wfn_pkg::CMD_ROTATE;
                            emit_value = rot_front_arg;
                        end
                    end
                    wfn_pkg::ST_ROT_FRONT:
                    begin
                        if (pend_next == wfn_pkg::ST_COR_OFFSET)
                        begin
                            emit_valid = 1'b1;
                            emit_code  = wfn_pkg::CMD_DIST;
                            emit_value = dist_arg;
                        end
                    end
                    wfn_pkg::ST_COR_OFFSET:
                    begin
                        if (pend_next == wfn_pkg::ST_ROT_BACK)
                        begin
                            emit_valid = 1'b1;
                            emit_code  = wfn_pkg::CMD_ROTATE;
                            emit_value = wfn_pkg::ROT_QUARTER_NEG;
                        end
                    end
                    wfn_pkg::ST_ROT_BACK, wfn_pkg::ST_GET_ANGLE:
                    begin
                        if (pend_next == wfn_pkg::ST_DRIVE)
                        begin
                            emit_valid = 1'b1;
                            emit_code  = wfn_pkg::CMD_FORWARD;
                            emit_value = wfn_pkg::FORWARD_ARG;
                        end
                    end
                    wfn_pkg::ST_DRIVE:
                    begin
                        if (pend_next == wfn_pkg::ST_GET_ANGLE)
                        begin
                            emit_valid  = 1'b1;
                            emit_code   = wfn_pkg::CMD_ROTATE;
                            emit_value  = ang_neg;
                            corner_next = 1'b1;
                        end
                    end
                    default: ;
                endcase

                // Commit on fresh data or in corner mode
                if (fresh_reg || corner_next)
                begin
                    fresh_next = 1'b0;
                    cur_next   = pend_next;
                end
            end
            wfn_pkg::KIND_SENSOR:
            begin
                lat_off_next   = word.wall_offset;
                lat_ang_next   = word.wall_angle;
                lat_front_next = word.front_distance;
                fresh_next     = 1'b1;
            end
            wfn_pkg::KIND_ROT_DONE:
            begin
                rot_next = 1'b1;
            end
            wfn_pkg::KIND_DIST_DONE:
            begin
                dist_next = 1'b1;
            end
            wfn_pkg::KIND_STOP:
            begin
                emit_valid = 1'b1;
                emit_code  = wfn_pkg::CMD_PAUSE;
                cur_next   = wfn_pkg::ST_IDLE;
                pend_next  = wfn_pkg::ST_IDLE;
                run_next   = 1'b0;
            end
            wfn_pkg::KIND_CONTINUE:
            begin
                if (!run_reg)
                begin
                    emit_valid = 1'b1;
                    emit_code  = wfn_pkg::CMD_CONT;
                    run_next   = 1'b1;
                end
            end
            wfn_pkg::KIND_PAUSE:
            begin
                if (run_reg)
                begin
                    emit_valid = 1'b1;
                    emit_code  = wfn_pkg::CMD_PAUSE;
                    run_next   = 1'b0;
                end
            end
            wfn_pkg::KIND_RESTART:
            begin
                cur_next  = wfn_pkg::ST_GET_OFFSET;
                pend_next = wfn_pkg::ST_GET_OFFSET;
            end
            default: ;
        endcase
    end

    // Advance state when the event moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= wfn_pkg::ST_IDLE;
            pend_reg      <= wfn_pkg::ST_IDLE;
            corner_reg    <= 1'b0;
            rot_reg       <= 1'b0;
            dist_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
            run_reg       <= 1'b0;
            lat_off_reg   <= '0;
            lat_ang_reg   <= '0;
            lat_front_reg <= '0;
        end
        else if (advance)
        begin
            cur_reg       <= cur_next;
            pend_reg      <= pend_next;
            corner_reg    <= corner_next;
            rot_reg       <= rot_next;
            dist_reg      <= dist_next;
            fresh_reg     <= fresh_next;
            run_reg       <= run_next;
            lat_off_reg   <= lat_off_next;
            lat_ang_reg   <= lat_ang_next;
            lat_front_reg <= lat_front_next;
        end
    end

    // Result word for this event
    assign res.cmd_valid   = emit_valid;
    assign res.cmd_code    = emit_code;
    assign res.cmd_value   = emit_value;
    assign res.seq_state   = wfn_pkg::nav_code(cur_next);
    assign res.corner_flag = corner_next;

endmodule

// File: hw/rtl/wfn_out_stage.sv
// ----------------------------------------------------------------------------
// wfn_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module wfn_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  wfn_pkg::result_t res_in,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output wfn_pkg::result_t res_out
);

    logic             valid_reg;
    wfn_pkg::result_t res_reg;

    // Room for a new word when empty or when the held word is taken
    assign free = !valid_reg || out_ready;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule
